@@ hdl/stereo_feedback_echo_macros.svh @@
// ----------------------------------------------------------------------------
// stereo_feedback_echo_macros.svh
// Assertion macros shared by the echo block, empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef STEREO_FEEDBACK_ECHO_MACROS_SVH
`define STEREO_FEEDBACK_ECHO_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SFE_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SFE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define SFE_ASSERT_SAME(lbl, ck, rn, ante, cons, msg)
`define SFE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

@@ hdl/sfe_pkg.sv @@
// ----------------------------------------------------------------------------
// sfe_pkg
// Types, widths and codes shared by the stereo feedback echo modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfe_pkg;

  // sample and arithmetic widths
  localparam int SMP_W  = 16;
  localparam int GAIN_W = 16;
  localparam int FRAC_W = 15;
  localparam int OPD_W  = SMP_W + 1;
  localparam int ACC_W  = 34;
  localparam int BIT_W  = $clog2(GAIN_W);

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 17;
  localparam int LEN_W     = 17;

  // default ring size
  localparam int MAX_FRAMES_DEF = 65536;

  // q1.15 unity and register reset values
  localparam logic [GAIN_W-1:0] UNITY_Q15    = 16'h8000;
  localparam logic [GAIN_W-1:0] DRY_RST      = 16'h8000;
  localparam logic [GAIN_W-1:0] WET_RST      = 16'h4000;
  localparam logic [GAIN_W-1:0] FB_RST       = 16'h4000;
  localparam logic [LEN_W-1:0]  DELAY_RST    = 17'd22050;

  // rounding bias and saturation bounds in accumulator width
  localparam logic signed [ACC_W-1:0] Q15_BIAS = 34'sd32767;
  localparam logic signed [ACC_W-1:0] SAT_HI   = 34'sd32767;
  localparam logic signed [ACC_W-1:0] SAT_LO   = -34'sd32768;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRY_GAIN      = 3'd0,
    CFG_WET_GAIN      = 3'd1,
    CFG_FEEDBACK_GAIN = 3'd2,
    CFG_SEND_ENABLE   = 3'd3,
    CFG_DELAY_FRAMES  = 3'd4
  } sfe_cfg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_MIX,
    ST_FBLD,
    ST_FB,
    ST_DONE
  } sfe_state_t;

  // payload words
  typedef struct packed {
    logic signed [SMP_W-1:0] right_smp;
    logic signed [SMP_W-1:0] left_smp;
  } sfe_in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] right_mix;
    logic signed [SMP_W-1:0] left_mix;
  } sfe_out_t;

  // lane control from the sequencer
  typedef struct packed {
    logic mix_load;
    logic fb_load;
    logic step;
  } sfe_lane_ctl_t;

endpackage

@@ hdl/sfe_ram.sv @@
// ----------------------------------------------------------------------------
// sfe_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/sfe_lane.sv @@
// ----------------------------------------------------------------------------
// sfe_lane
// One channel: bit-serial mix and feedback multiply-accumulate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfe_lane (
  input  logic                                   clk,
  input  sfe_pkg::sfe_lane_ctl_t                 ctl,
  input  logic signed [sfe_pkg::SMP_W-1:0]       x,
  input  logic signed [sfe_pkg::SMP_W-1:0]       dl,
  input  logic [sfe_pkg::GAIN_W-1:0]             dry_g,
  input  logic [sfe_pkg::GAIN_W-1:0]             wet_g,
  input  logic [sfe_pkg::GAIN_W-1:0]             fb_g,
  input  logic                                   send,
  output logic signed [sfe_pkg::SMP_W-1:0]       y,
  output logic signed [sfe_pkg::SMP_W-1:0]       wb
);

  import sfe_pkg::*;

  // divide by 32768 toward zero, then clip to 16 bits
  function automatic logic signed [SMP_W-1:0] trunc_sat(input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] bias;
    logic signed [ACC_W-1:0] q;
    bias = p[ACC_W-1] ? Q15_BIAS : '0;
    q    = (p + bias) >>> FRAC_W;
    if (q > SAT_HI) begin
      return SAT_HI[SMP_W-1:0];
    end else if (q < SAT_LO) begin
      return SAT_LO[SMP_W-1:0];
    end
    return q[SMP_W-1:0];
  endfunction

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [OPD_W-1:0] a_r, a_nxt;
  logic signed [OPD_W-1:0] b_r, b_nxt;
  logic [GAIN_W-1:0]       g0_r, g0_nxt;
  logic [GAIN_W-1:0]       g1_r, g1_nxt;
  logic signed [SMP_W-1:0] dl_r, dl_nxt;
  logic signed [SMP_W-1:0] y_r, y_nxt;
  logic signed [SMP_W-1:0] acc_sat;
  logic signed [ACC_W-1:0] term0, term1;
  logic signed [OPD_W-1:0] src;

  assign acc_sat = trunc_sat(acc_r);

  // partial products for the current gain bit, msb first
  assign term0 = g0_r[GAIN_W-1] ? ACC_W'(a_r) : '0;
  assign term1 = g1_r[GAIN_W-1] ? ACC_W'(b_r) : '0;

  // feedback source: delayed sample plus output when sending
  assign src = send ? (OPD_W'(dl_r) + OPD_W'(acc_sat)) : OPD_W'(dl_r);

  // operand load and shift-add step
  always_comb begin
    acc_nxt = acc_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    g0_nxt  = g0_r;
    g1_nxt  = g1_r;
    dl_nxt  = dl_r;
    y_nxt   = y_r;
    priority if (ctl.mix_load) begin
      acc_nxt = '0;
      a_nxt   = OPD_W'(x);
      b_nxt   = OPD_W'(dl);
      g0_nxt  = dry_g;
      g1_nxt  = wet_g;
      dl_nxt  = dl;
    end else if (ctl.fb_load) begin
      y_nxt   = acc_sat;
      acc_nxt = '0;
      a_nxt   = src;
      b_nxt   = '0;
      g0_nxt  = fb_g;
      g1_nxt  = '0;
    end else if (ctl.step) begin
      acc_nxt = (acc_r <<< 1) + term0 + term1;
      g0_nxt  = g0_r << 1;
      g1_nxt  = g1_r << 1;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    g0_r  <= g0_nxt;
    g1_r  <= g1_nxt;
    dl_r  <= dl_nxt;
    y_r   <= y_nxt;
  end

  assign y  = y_r;
  assign wb = acc_sat;

endmodule

@@ hdl/stereo_feedback_echo.sv @@
// ----------------------------------------------------------------------------
// stereo_feedback_echo
// Stereo feedback delay: mixes each frame with the delayed frame and writes
// a scaled copy back into the delay ring.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole delay memory to zero, one frame per
// cycle, and in_stall stays high until it is done. Each frame then runs
// through these steps until the next acceptance: the accepting cycle, which
// also issues the memory read, the load of the lane operands, the bit-serial
// mix multiply-accumulate (one gain bit per cycle), the load of the feedback
// operands, the bit-serial feedback product, and the write-back with the load
// of the output register. Both channels run side by side in their own lane.
// A held result waits in the output register while the next frame may already
// be accepted; the write-back of that next frame waits until the held result
// is taken.
`timescale 1ns / 1ps
`include "stereo_feedback_echo_macros.svh"

module stereo_feedback_echo #(
  parameter int MAX_FRAMES = sfe_pkg::MAX_FRAMES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sfe_pkg::sfe_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sfe_pkg::sfe_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [sfe_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [sfe_pkg::CFG_W-1:0]         cfg_wdata
);

  import sfe_pkg::*;

  localparam int AW = $clog2(MAX_FRAMES);
  localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
  localparam int MW = 2 * SMP_W;

  sfe_state_t    state_r, state_nxt;
  sfe_lane_ctl_t ctl;

  logic [GAIN_W-1:0] dry_r, wet_r, fb_r;
  logic              send_r;
  logic [LEN_W-1:0]  delay_r;
  logic [GAIN_W-1:0] dry_g, wet_g, fb_g;

  logic [AW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  sfe_in_t          in_r;
  logic             out_valid_r, out_valid_nxt;
  sfe_out_t         out_r;
  logic             out_ld;
  logic             accept;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_addr;
  logic [MW-1:0]    ram_wdata, ram_rdata;

  logic [CW-1:0]    dly_ext, max_ext, len, pos_inc;

  logic signed [SMP_W-1:0] yl, yr, wbl, wbr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dry_r   <= DRY_RST;
      wet_r   <= WET_RST;
      fb_r    <= FB_RST;
      send_r  <= 1'b1;
      delay_r <= DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DRY_GAIN:      dry_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_WET_GAIN:      wet_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_FEEDBACK_GAIN: fb_r    <= cfg_wdata[GAIN_W-1:0];
        CFG_SEND_ENABLE:   send_r  <= cfg_wdata[0];
        CFG_DELAY_FRAMES:  delay_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // gains above one act as one
  assign dry_g = (dry_r > UNITY_Q15) ? UNITY_Q15 : dry_r;
  assign wet_g = (wet_r > UNITY_Q15) ? UNITY_Q15 : wet_r;
  assign fb_g  = (fb_r > UNITY_Q15) ? UNITY_Q15 : fb_r;

  // ring length clamped to 1..MAX_FRAMES and position wrap
  assign dly_ext = CW'(delay_r);
  assign max_ext = CW'(MAX_FRAMES);
  assign len     = (dly_ext == '0) ? CW'(1) : ((dly_ext > max_ext) ? max_ext : dly_ext);
  assign pos_inc = CW'(pos_r) + CW'(1);

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    clr_nxt   = clr_r;
    bit_nxt   = bit_r;
    pos_nxt   = pos_r;
    out_ld    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_FRAMES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          ram_re    = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctl.mix_load = 1'b1;
        state_nxt    = ST_MIX;
      end
      ST_MIX: begin
        ctl.step = 1'b1;
        bit_nxt  = bit_r + BIT_W'(1);
        if (bit_r == BIT_W'(GAIN_W - 1)) begin
          bit_nxt   = '0;
          state_nxt = ST_FBLD;
        end
      end
      ST_FBLD: begin
        ctl.fb_load = 1'b1;
        state_nxt   = ST_FB;
      end
      ST_FB: begin
        ctl.step = 1'b1;
        bit_nxt  = bit_r + BIT_W'(1);
        if (bit_r == BIT_W'(GAIN_W - 1)) begin
          bit_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          ram_we    = 1'b1;
          out_ld    = 1'b1;
          pos_nxt   = (pos_inc >= len) ? '0 : pos_inc[AW-1:0];
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      bit_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      bit_r   <= bit_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // input word latch
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

  // delay memory port
  assign ram_addr  = (state_r == ST_CLEAR) ? clr_r : pos_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : {wbr, wbl};

  sfe_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_FRAMES)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // channel lanes
  sfe_lane u_left (
    .clk   (clk),
    .ctl   (ctl),
    .x     (in_r.left_smp),
    .dl    ($signed(ram_rdata[SMP_W-1:0])),
    .dry_g (dry_g),
    .wet_g (wet_g),
    .fb_g  (fb_g),
    .send  (send_r),
    .y     (yl),
    .wb    (wbl)
  );

  sfe_lane u_right (
    .clk   (clk),
    .ctl   (ctl),
    .x     (in_r.right_smp),
    .dl    ($signed(ram_rdata[MW-1:SMP_W])),
    .dry_g (dry_g),
    .wet_g (wet_g),
    .fb_g  (fb_g),
    .send  (send_r),
    .y     (yr),
    .wb    (wbr)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_r.left_mix  <= yl;
      out_r.right_mix <= yr;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `SFE_ASSERT_NEXT(a_accept_load, clk, rst_n, accept, state_r == ST_LOAD, "no load after accept")
  `SFE_ASSERT_NEXT(a_out_shown, clk, rst_n, out_ld, out_valid && state_r == ST_IDLE, "result lost")
  `SFE_ASSERT_SAME(a_wr_phase, clk, rst_n, ram_we, state_r == ST_CLEAR || state_r == ST_DONE, "bad write")

endmodule
